/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define GQT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition that must never be seen outside reset
`define GQT_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

/* sv/gqt_pkg.sv */
package gqt_pkg;

   // field widths
   localparam int SHAPE_W = 16;
   localparam int M_W = 7;
   localparam int K_CFG_W = 2;
   localparam int THR_W = 6;
   localparam int VAL_W = 7;
   localparam int SPAN_W = 5;
   localparam int CW = SHAPE_W - 1;
   localparam int RANK_W = 16;
   localparam int POP_W = 4;
   localparam int SUM_W = 17;

   // defaults for the top level parameters
   localparam int DEF_MAX_SPAN = 16;
   localparam int DEF_MAX_K = 3;
   localparam int DEF_MAX_SUBSETS = 576;

   // register reset values and window clamp
   localparam logic [M_W-1:0] M_RESET = 7'd50;
   localparam logic [K_CFG_W-1:0] K_RESET = 2'd3;
   localparam logic [M_W-1:0] M_LIMIT = 7'd64;

   typedef enum logic [0:0] {
      CSR_WINDOW_LENGTH = 1'b0,
      CSR_MAX_MISMATCHES = 1'b1
   } csr_index_type;

   // classified word handed from front to back
   typedef struct packed {
      logic [SHAPE_W-1:0] shape;
      logic [SPAN_W-1:0] span;
      logic [M_W-1:0] m;
      logic [K_CFG_W-1:0] k;
      logic trivial;
      logic [THR_W-1:0] result;
   } item_type;

   typedef struct packed {
      logic idle;
      logic pop;
   } back_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_RUN,
      ST_DRAIN,
      ST_SCAN,
      ST_SCAN_WAIT,
      ST_FINISH
   } back_state_type;

   // binomial coefficient from a constant pascal triangle
   function automatic logic [RANK_W-1:0] binom(input logic [4:0] n, input logic [4:0] r);
      logic [RANK_W-1:0] pascal [0:16][0:16];
      logic [RANK_W-1:0] res;
      for (int a = 0; a <= 16; a++) begin
         for (int b = 0; b <= 16; b++) begin
            if (b == 0) begin
               pascal[a][b] = RANK_W'(1);
            end else if (a == 0) begin
               pascal[a][b] = '0;
            end else begin
               pascal[a][b] = pascal[a-1][b-1] + pascal[a-1][b];
            end
         end
      end
      if (n > 5'd16 || r > 5'd16) begin
         res = '0;
      end else begin
         res = pascal[n][r];
      end
      return res;
   endfunction

endpackage

/* sv/gqt_front.sv */
module gqt_front #(
   parameter int MAX_SPAN = gqt_pkg::DEF_MAX_SPAN,
   parameter int MAX_K = gqt_pkg::DEF_MAX_K
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [gqt_pkg::SHAPE_W-1:0] req_shape_mask,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [0:0] csr_index,
   input  logic [gqt_pkg::M_W-1:0] csr_wdata,
   output logic push,
   output gqt_pkg::item_type push_item,
   input  logic q_full
);

   logic [gqt_pkg::M_W-1:0] m_ff;
   logic [gqt_pkg::K_CFG_W-1:0] k_ff;
   logic [gqt_pkg::M_W-1:0] m_eff;
   logic [gqt_pkg::M_W-1:0] m_less;
   logic [gqt_pkg::K_CFG_W-1:0] k_eff;
   logic [gqt_pkg::SPAN_W-1:0] span;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;
   assign push = req_valid && !q_full;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         m_ff <= gqt_pkg::M_RESET;
         k_ff <= gqt_pkg::K_RESET;
      end else if (csr_valid && csr_ready) begin
         case (gqt_pkg::csr_index_type'(csr_index))
            gqt_pkg::CSR_WINDOW_LENGTH: m_ff <= csr_wdata;
            gqt_pkg::CSR_MAX_MISMATCHES: k_ff <= csr_wdata[gqt_pkg::K_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp window and mismatch count
   always_comb begin
      if (m_ff == '0) begin
         m_eff = gqt_pkg::M_W'(1);
      end else if (m_ff > gqt_pkg::M_LIMIT) begin
         m_eff = gqt_pkg::M_LIMIT;
      end else begin
         m_eff = m_ff;
      end
      m_less = m_eff - gqt_pkg::M_W'(1);
      if (int'(k_ff) > MAX_K) begin
         k_eff = gqt_pkg::K_CFG_W'(MAX_K);
      end else begin
         k_eff = k_ff;
      end
   end

   // span is the top set bit plus one
   always_comb begin
      span = '0;
      for (int l = 0; l < gqt_pkg::SHAPE_W; l++) begin
         if (req_shape_mask[l]) begin
            span = gqt_pkg::SPAN_W'(l + 1);
         end
      end
   end

   // classify: narrow and oversized shapes are answered here
   always_comb begin
      push_item.shape = req_shape_mask;
      push_item.span = span;
      push_item.m = m_eff;
      push_item.k = k_eff;
      push_item.trivial = (span <= gqt_pkg::SPAN_W'(1)) || (int'(span) > MAX_SPAN);
      if (span == gqt_pkg::SPAN_W'(1)) begin
         push_item.result = m_less[gqt_pkg::THR_W-1:0];
      end else begin
         push_item.result = '0;
      end
   end

endmodule

/* sv/gqt_queue.sv */
module gqt_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  gqt_pkg::item_type push_item,
   output logic full,
   input  logic pop,
   output gqt_pkg::item_type pop_item,
   output logic valid
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   gqt_pkg::item_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign valid = (count_ff != '0);
   assign pop_item = slot_ff[rd_ptr_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* sv/gqt_back.sv */
module gqt_back #(
   parameter int MAX_K = gqt_pkg::DEF_MAX_K,
   parameter int MAX_SUBSETS = gqt_pkg::DEF_MAX_SUBSETS
) (
   input  logic clock,
   input  logic reset,
   input  logic q_valid,
   input  gqt_pkg::item_type q_item,
   output gqt_pkg::back_status_type status,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [gqt_pkg::THR_W-1:0] rsp_threshold
);

   localparam int KW = (MAX_K < 2) ? 1 : $clog2(MAX_K + 1);
   localparam int IDX_W = $clog2(MAX_SUBSETS);
   localparam int CNT_W = $clog2(MAX_SUBSETS + 1);
   localparam int DEPTH = (MAX_K + 1) * MAX_SUBSETS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CW = gqt_pkg::CW;
   localparam int VAL_W = gqt_pkg::VAL_W;
   localparam int RANK_W = gqt_pkg::RANK_W;
   localparam int POP_W = gqt_pkg::POP_W;
   localparam int SUM_W = gqt_pkg::SUM_W;

   // next subset of the same size, in increasing order
   function automatic logic [CW-1:0] next_comb(input logic [CW-1:0] c);
      logic [CW:0] cx;
      logic [CW:0] u;
      logic [CW:0] v;
      logic [CW:0] d;
      logic [CW:0] r;
      int z;
      cx = {1'b0, c};
      u = cx & (~cx + 1'b1);
      v = cx + u;
      d = (v ^ cx) >> 2;
      z = 0;
      for (int b = CW - 1; b >= 0; b--) begin
         if (c[b]) begin
            z = b;
         end
      end
      d = d >> z;
      r = v | d;
      return r[CW-1:0];
   endfunction

   gqt_pkg::back_state_type state_ff;
   gqt_pkg::back_state_type state_in;
   gqt_pkg::item_type item_ff;

   // group bounds
   logic [SUM_W-1:0] start_ff [MAX_K+1];
   logic [SUM_W-1:0] start_in [MAX_K+1];
   logic [CNT_W-1:0] gend_ff [MAX_K+1];
   logic [CNT_W-1:0] gend_in [MAX_K+1];

   // sweep counters and subset generator
   logic [gqt_pkg::M_W-1:0] layer_ff;
   logic [KW-1:0] j_ff;
   logic [KW-1:0] g_ff;
   logic [CNT_W-1:0] l_ff;
   logic [CW-1:0] c_ff;
   logic first_ff;
   logic bank_ff;
   logic [VAL_W-1:0] best_ff;
   logic rsp_valid_ff;
   logic [gqt_pkg::THR_W-1:0] rsp_threshold_ff;

   logic [KW-1:0] kb;
   logic pop_q, issue, scan_issue, setup, load_rsp, drain_done, pipe_empty;
   logic l_last_j, j_last, layer_last, scan_last, g_last;

   // stage 0 signals
   logic [gqt_pkg::SHAPE_W-1:0] wfull;
   logic [CW-1:0] wmask, c_lo, c_hi;
   logic [3:0] span_m2;
   logic lastmiss;
   logic [RANK_W-1:0] t_lo [CW];
   logic [RANK_W-1:0] t_hi [CW];

   // stage 1 registers
   logic p1_v_ff;
   logic [RANK_W-1:0] t_lo_ff [CW];
   logic [RANK_W-1:0] t_hi_ff [CW];
   logic [POP_W-1:0] pop_lo1_ff, pop_hi1_ff;
   logic hit1_ff, tj_ok1_ff;
   logic [KW-1:0] tj1_ff, j1_ff;
   logic [IDX_W-1:0] l1_ff;
   logic [RANK_W-1:0] rank_lo, rank_hi;

   // stage 2 registers
   logic p2_v_ff;
   logic [RANK_W-1:0] rank_lo_ff, rank_hi_ff;
   logic [POP_W-1:0] pop_lo2_ff, pop_hi2_ff;
   logic hit2_ff, tj_ok2_ff;
   logic [KW-1:0] tj2_ff, j2_ff;
   logic [IDX_W-1:0] l2_ff;
   logic [KW-1:0] psel_lo, psel_hi;
   logic [SUM_W-1:0] idx_lo, idx_hi;
   logic ok_lo, ok_hi;
   logic [ADDR_W-1:0] ra_lo, ra_hi;

   // stage 3 registers
   logic p3_v_ff;
   logic ok_lo3_ff, ok_hi3_ff, hit3_ff;
   logic [KW-1:0] j3_ff;
   logic [IDX_W-1:0] l3_ff;
   logic scan_v_ff;

   // layer memories, one read and one written per layer
   logic [VAL_W-1:0] bank0_mem [DEPTH];
   logic [VAL_W-1:0] bank1_mem [DEPTH];
   logic [VAL_W-1:0] rd0_lo_ff, rd0_hi_ff, rd1_lo_ff, rd1_hi_ff;
   logic [VAL_W-1:0] rd_lo, rd_hi, v_new, w_hi;
   logic [ADDR_W-1:0] wa;

   assign kb = KW'(item_ff.k);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_threshold = rsp_threshold_ff;
   assign status.idle = (state_ff == gqt_pkg::ST_IDLE);
   assign status.pop = pop_q;
   assign pipe_empty = !p1_v_ff && !p2_v_ff && !p3_v_ff;

   // sweep end conditions
   always_comb begin
      l_last_j = ((l_ff + CNT_W'(1)) == gend_ff[j_ff]);
      g_last = ((l_ff + CNT_W'(1)) == gend_ff[g_ff]);
      j_last = (j_ff == kb);
      layer_last = (layer_ff == item_ff.m);
      scan_last = ((l_ff + CNT_W'(1)) == gend_ff[kb]);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gqt_pkg::ST_IDLE: if (q_valid) state_in = gqt_pkg::ST_SETUP;
         gqt_pkg::ST_SETUP: begin
            if (item_ff.trivial || (item_ff.m < gqt_pkg::M_W'(item_ff.span))) begin
               state_in = gqt_pkg::ST_FINISH;
            end else begin
               state_in = gqt_pkg::ST_RUN;
            end
         end
         gqt_pkg::ST_RUN: if (l_last_j && j_last) state_in = gqt_pkg::ST_DRAIN;
         gqt_pkg::ST_DRAIN: begin
            if (pipe_empty) begin
               state_in = layer_last ? gqt_pkg::ST_SCAN : gqt_pkg::ST_RUN;
            end
         end
         gqt_pkg::ST_SCAN: if (scan_last) state_in = gqt_pkg::ST_SCAN_WAIT;
         gqt_pkg::ST_SCAN_WAIT: state_in = gqt_pkg::ST_FINISH;
         gqt_pkg::ST_FINISH: if (!rsp_valid_ff || !rsp_stall) state_in = gqt_pkg::ST_IDLE;
         default: state_in = gqt_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      pop_q = (state_ff == gqt_pkg::ST_IDLE) && q_valid;
      setup = (state_ff == gqt_pkg::ST_SETUP);
      issue = (state_ff == gqt_pkg::ST_RUN);
      scan_issue = (state_ff == gqt_pkg::ST_SCAN);
      drain_done = (state_ff == gqt_pkg::ST_DRAIN) && pipe_empty;
      load_rsp = (state_ff == gqt_pkg::ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gqt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // group starts and capped group ends
   always_comb begin
      logic [SUM_W-1:0] acc;
      acc = '0;
      for (int g = 0; g <= MAX_K; g++) begin
         start_in[g] = acc;
         acc = acc + SUM_W'(gqt_pkg::binom(5'(item_ff.span - 5'd1), 5'(g)));
         gend_in[g] = (int'(acc) > MAX_SUBSETS) ? CNT_W'(MAX_SUBSETS) : CNT_W'(acc);
      end
   end

   // item, bounds, counters and generator
   always_ff @(posedge clock) begin
      if (pop_q) begin
         item_ff <= q_item;
      end
      if (setup) begin
         start_ff <= start_in;
         gend_ff <= gend_in;
         layer_ff <= gqt_pkg::M_W'(item_ff.span);
         first_ff <= 1'b1;
         bank_ff <= 1'b0;
         if (item_ff.trivial) begin
            best_ff <= VAL_W'(item_ff.result);
         end else if (item_ff.m < gqt_pkg::M_W'(item_ff.span)) begin
            best_ff <= '0;
         end else begin
            best_ff <= '1;
         end
      end
      if (setup || drain_done) begin
         j_ff <= '0;
         g_ff <= '0;
         l_ff <= '0;
         c_ff <= '0;
      end
      if (drain_done) begin
         layer_ff <= layer_ff + gqt_pkg::M_W'(1);
         first_ff <= 1'b0;
         bank_ff <= !bank_ff;
      end
      if (issue) begin
         if (l_last_j) begin
            j_ff <= j_ff + KW'(1);
            g_ff <= '0;
            l_ff <= '0;
            c_ff <= '0;
         end else begin
            l_ff <= l_ff + CNT_W'(1);
            if (g_last) begin
               g_ff <= g_ff + KW'(1);
               c_ff <= CW'((1 << (int'(g_ff) + 1)) - 1);
            end else begin
               c_ff <= next_comb(c_ff);
            end
         end
      end
      if (scan_issue) begin
         l_ff <= l_ff + CNT_W'(1);
      end
      if (scan_v_ff && (rd_lo < best_ff)) begin
         best_ff <= rd_lo;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_threshold_ff <= best_ff[gqt_pkg::THR_W-1:0];
      end
   end

   // stage 0: neighbour subsets and per-bit rank terms
   always_comb begin
      wfull = (gqt_pkg::SHAPE_W'(1) << (item_ff.span - gqt_pkg::SPAN_W'(1)))
              - gqt_pkg::SHAPE_W'(1);
      wmask = wfull[CW-1:0];
      c_lo = {c_ff[CW-2:0], 1'b1} & wmask;
      c_hi = {c_ff[CW-2:0], 1'b0} & wmask;
      span_m2 = 4'(item_ff.span - gqt_pkg::SPAN_W'(2));
      lastmiss = c_ff[span_m2];
      for (int b = 0; b < CW; b++) begin
         t_lo[b] = c_lo[b] ? gqt_pkg::binom(5'(b),
                   5'($countones(c_lo & CW'((1 << b) - 1)) + 1)) : '0;
         t_hi[b] = c_hi[b] ? gqt_pkg::binom(5'(b),
                   5'($countones(c_hi & CW'((1 << b) - 1)) + 1)) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
         scan_v_ff <= 1'b0;
      end else begin
         p1_v_ff <= issue;
         p2_v_ff <= p1_v_ff;
         p3_v_ff <= p2_v_ff;
         scan_v_ff <= scan_issue;
      end
   end

   always_ff @(posedge clock) begin
      t_lo_ff <= t_lo;
      t_hi_ff <= t_hi;
      pop_lo1_ff <= POP_W'($countones(c_lo));
      pop_hi1_ff <= POP_W'($countones(c_hi));
      hit1_ff <= ((item_ff.shape[gqt_pkg::SHAPE_W-1:1] & c_ff) == '0);
      tj_ok1_ff <= !((j_ff == '0) && lastmiss);
      tj1_ff <= j_ff - KW'(lastmiss);
      j1_ff <= j_ff;
      l1_ff <= l_ff[IDX_W-1:0];
   end

   // stage 1: sum the rank terms
   always_comb begin
      rank_lo = '0;
      rank_hi = '0;
      for (int b = 0; b < CW; b++) begin
         rank_lo = rank_lo + t_lo_ff[b];
         rank_hi = rank_hi + t_hi_ff[b];
      end
   end

   always_ff @(posedge clock) begin
      rank_lo_ff <= rank_lo;
      rank_hi_ff <= rank_hi;
      pop_lo2_ff <= pop_lo1_ff;
      pop_hi2_ff <= pop_hi1_ff;
      hit2_ff <= hit1_ff;
      tj_ok2_ff <= tj_ok1_ff;
      tj2_ff <= tj1_ff;
      j2_ff <= j1_ff;
      l2_ff <= l1_ff;
   end

   // stage 2: table index, bound check, layer read address
   always_comb begin
      psel_lo = (int'(pop_lo2_ff) <= MAX_K) ? KW'(pop_lo2_ff) : '0;
      psel_hi = (int'(pop_hi2_ff) <= MAX_K) ? KW'(pop_hi2_ff) : '0;
      idx_lo = start_ff[psel_lo] + SUM_W'(rank_lo_ff);
      idx_hi = start_ff[psel_hi] + SUM_W'(rank_hi_ff);
      ok_lo = tj_ok2_ff && (int'(pop_lo2_ff) <= int'(tj2_ff))
              && (int'(idx_lo) < int'(gend_ff[tj2_ff]));
      ok_hi = tj_ok2_ff && (int'(pop_hi2_ff) <= int'(tj2_ff))
              && (int'(idx_hi) < int'(gend_ff[tj2_ff]));
      if (scan_issue) begin
         ra_lo = ADDR_W'(int'(kb) * MAX_SUBSETS + int'(l_ff[IDX_W-1:0]));
      end else if (ok_lo) begin
         ra_lo = ADDR_W'(int'(tj2_ff) * MAX_SUBSETS + int'(idx_lo[IDX_W-1:0]));
      end else begin
         ra_lo = '0;
      end
      if (ok_hi) begin
         ra_hi = ADDR_W'(int'(tj2_ff) * MAX_SUBSETS + int'(idx_hi[IDX_W-1:0]));
      end else begin
         ra_hi = '0;
      end
   end

   always_ff @(posedge clock) begin
      rd0_lo_ff <= bank0_mem[ra_lo];
      rd0_hi_ff <= bank0_mem[ra_hi];
      rd1_lo_ff <= bank1_mem[ra_lo];
      rd1_hi_ff <= bank1_mem[ra_hi];
      ok_lo3_ff <= ok_lo;
      ok_hi3_ff <= ok_hi;
      hit3_ff <= hit2_ff;
      j3_ff <= j2_ff;
      l3_ff <= l2_ff;
   end

   // stage 3: min-plus update, the first layer reads zeros
   always_comb begin
      logic have;
      if (first_ff) begin
         rd_lo = '0;
         rd_hi = '0;
      end else begin
         rd_lo = bank_ff ? rd1_lo_ff : rd0_lo_ff;
         rd_hi = bank_ff ? rd1_hi_ff : rd0_hi_ff;
      end
      have = 1'b0;
      v_new = '0;
      w_hi = rd_hi + VAL_W'(hit3_ff);
      if (ok_lo3_ff) begin
         v_new = rd_lo;
         have = 1'b1;
      end
      if (ok_hi3_ff && (!have || (w_hi < v_new))) begin
         v_new = w_hi;
      end
      wa = ADDR_W'(int'(j3_ff) * MAX_SUBSETS + int'(l3_ff));
   end

   always_ff @(posedge clock) begin
      if (p3_v_ff && bank_ff) begin
         bank0_mem[wa] <= v_new;
      end
      if (p3_v_ff && !bank_ff) begin
         bank1_mem[wa] <= v_new;
      end
   end

endmodule

/* sv/gapped_qgram_threshold_dp.sv */
// narrow, oversized or longer-than-window shapes pass from setup straight to the result word;
// otherwise the back end sweeps L = m-span+1 layers of U updates each, U = sum of the group
// ends for mismatch rows 0..k, then scans E entries, E = group end of row k (span 16, k 3: U = 714)
// one layer update per cycle within a layer's sweep, through the rank pipeline and a two-read layer memory
// throughput: one shape at a time in the back end, the front queue holds two more
// reset: synchronous, clears control and config (m 50, k 3); layer memories are not cleared
`include "assert_macros.svh"

module gapped_qgram_threshold_dp #(
   parameter int MAX_SPAN = gqt_pkg::DEF_MAX_SPAN,
   parameter int MAX_K = gqt_pkg::DEF_MAX_K,
   parameter int MAX_SUBSETS = gqt_pkg::DEF_MAX_SUBSETS
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [gqt_pkg::SHAPE_W-1:0] req_shape_mask,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [gqt_pkg::THR_W-1:0] rsp_threshold,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [0:0] csr_index,
   input  logic [gqt_pkg::M_W-1:0] csr_wdata
);

   logic push;
   logic q_full;
   logic q_valid;
   gqt_pkg::item_type push_item;
   gqt_pkg::item_type q_item;
   gqt_pkg::back_status_type back_status;

   // accept and classify
   gqt_front #(
      .MAX_SPAN(MAX_SPAN),
      .MAX_K(MAX_K)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_shape_mask(req_shape_mask),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .push(push),
      .push_item(push_item),
      .q_full(q_full)
   );

   // decoupling queue
   gqt_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_item(push_item),
      .full(q_full),
      .pop(back_status.pop),
      .pop_item(q_item),
      .valid(q_valid)
   );

   // table sweep and min-plus recurrence
   gqt_back #(
      .MAX_K(MAX_K),
      .MAX_SUBSETS(MAX_SUBSETS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .q_valid(q_valid),
      .q_item(q_item),
      .status(back_status),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_threshold(rsp_threshold)
   );

   // checks
   `GQT_ASSERT_IMPLY(a_rsp_busy, clock, reset, $rose(rsp_valid), $past(!back_status.idle), "rsp idle")
   `GQT_ASSERT_NEVER(a_pop_has_item, clock, reset, back_status.pop && !q_valid, "pop when empty")
   `GQT_ASSERT_IMPLY(a_quiet_after_reset, clock, reset, $fell(reset), !rsp_valid, "rsp after reset")

endmodule

/* dv/gqt_checker.sv */
`timescale 1ns / 100ps

module gqt_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_stall,
   input  logic [gqt_pkg::SHAPE_W-1:0] req_shape_mask,
   input  logic rsp_valid,
   input  logic rsp_stall,
   input  logic [gqt_pkg::THR_W-1:0] rsp_threshold,
   input  logic csr_valid,
   input  logic csr_ready,
   input  logic [0:0] csr_index,
   input  logic [gqt_pkg::M_W-1:0] csr_wdata,
   output int error_count,
   output int pending_count
);

   localparam int SUBSET_DEPTH = 576;
   localparam int MISS_ROWS = 4;

   logic [gqt_pkg::M_W-1:0] window_len;
   logic [gqt_pkg::K_CFG_W-1:0] miss_limit;
   logic [gqt_pkg::THR_W-1:0] threshold_queue[$];

   // threshold of a shape by min-plus over the window layers
   function automatic logic [gqt_pkg::THR_W-1:0] shape_threshold(
      input logic [gqt_pkg::SHAPE_W-1:0] shape,
      input logic [gqt_pkg::M_W-1:0] m_reg,
      input logic [gqt_pkg::K_CFG_W-1:0] k_reg);
      int m;
      int k;
      int span;
      int cnt;
      int unsigned full;
      int unsigned last;
      int unsigned t;
      int unsigned msk;
      int subs[0:SUBSET_DEPTH-1];
      int nb_lo[0:SUBSET_DEPTH-1];
      int nb_hi[0:SUBSET_DEPTH-1];
      int gend[0:MISS_ROWS-1];
      int cur[0:MISS_ROWS-1][0:SUBSET_DEPTH-1];
      int nxt[0:MISS_ROWS-1][0:SUBSET_DEPTH-1];
      int pos_of[int];
      int v;
      int w;
      int tj;
      int lim;
      int hit;
      int best;
      m = (m_reg < 1) ? 1 : ((m_reg > 64) ? 64 : int'(m_reg));
      k = k_reg;
      span = 0;
      for (int b = 0; b < gqt_pkg::SHAPE_W; b++) begin
         if (shape[b]) span = b + 1;
      end
      if (span == 0) return '0;
      if (span == 1) return gqt_pkg::THR_W'(m - 1);
      full = (32'd1 << span) - 1;
      last = 32'd1 << (span - 1);
      // subsets of positions 1..span-1, grouped by number missing
      cnt = 0;
      for (int i = 0; i <= k; i++) begin
         for (int unsigned c = 0; c < last; c++) begin
            if ($countones(c) == i && cnt < SUBSET_DEPTH) begin
               subs[cnt] = int'((~c << 1) & full);
               cnt++;
            end
         end
         gend[i] = cnt;
      end
      for (int i = 0; i < cnt; i++) begin
         if (!pos_of.exists(subs[i])) pos_of[subs[i]] = i;
      end
      // shifted neighbours
      for (int i = 0; i < cnt; i++) begin
         t = (subs[i] & ~last) << 1;
         nb_lo[i] = pos_of.exists(int'(t)) ? pos_of[int'(t)] : -1;
         nb_hi[i] = pos_of.exists(int'(t | 2)) ? pos_of[int'(t | 2)] : -1;
      end
      for (int j = 0; j < MISS_ROWS; j++) begin
         for (int l = 0; l < SUBSET_DEPTH; l++) cur[j][l] = 0;
      end
      // layer recurrence
      for (int layer = span; layer <= m; layer++) begin
         for (int j = 0; j <= k; j++) begin
            for (int l = 0; l < gend[j]; l++) begin
               msk = subs[l];
               hit = ((shape & ~(msk | 1)) == 0) ? 1 : 0;
               v = 255;
               tj = j - (((msk & last) == 0) ? 1 : 0);
               if (tj >= 0) begin
                  lim = gend[tj];
                  if (nb_lo[l] >= 0 && nb_lo[l] < lim) v = cur[tj][nb_lo[l]];
                  if (nb_hi[l] >= 0 && nb_hi[l] < lim) begin
                     w = cur[tj][nb_hi[l]] + hit;
                     if (w < v) v = w;
                  end
               end
               if (v == 255) v = 0;
               nxt[j][l] = v;
            end
         end
         for (int j = 0; j <= k; j++) begin
            for (int l = 0; l < gend[j]; l++) cur[j][l] = nxt[j][l];
         end
      end
      best = cur[k][0];
      for (int l = 1; l < gend[k]; l++) begin
         if (cur[k][l] < best) best = cur[k][l];
      end
      return gqt_pkg::THR_W'(best);
   endfunction

   task automatic report_mismatch(input string what, input int exp_val, input int got_val);
      $display("%0t: mismatch %s: expected %0d, got %0d", $realtime, what, exp_val, got_val);
      error_count++;
   endtask

   assign pending_count = threshold_queue.size();

   // config tracking, prediction on accepted shapes, result compare
   always @(posedge clock) begin
      if (reset) begin
         window_len <= gqt_pkg::M_RESET;
         miss_limit <= gqt_pkg::K_RESET;
         threshold_queue.delete();
         error_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (gqt_pkg::csr_index_type'(csr_index))
               gqt_pkg::CSR_WINDOW_LENGTH: window_len <= csr_wdata;
               gqt_pkg::CSR_MAX_MISMATCHES: miss_limit <= csr_wdata[gqt_pkg::K_CFG_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            threshold_queue.push_back(shape_threshold(req_shape_mask, window_len, miss_limit));
         end
         if (rsp_valid && !rsp_stall) begin
            if (threshold_queue.size() == 0) begin
               report_mismatch("unexpected result word", -1, rsp_threshold);
            end else if (threshold_queue[0] != rsp_threshold) begin
               report_mismatch("threshold", threshold_queue[0], rsp_threshold);
               void'(threshold_queue.pop_front());
            end else begin
               void'(threshold_queue.pop_front());
            end
         end
      end
   end

endmodule

/* dv/tb_gapped_qgram_threshold_dp.sv */
`timescale 1ns / 100ps

module tb_gapped_qgram_threshold_dp;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [gqt_pkg::SHAPE_W-1:0] req_shape_mask;
   logic rsp_valid;
   logic rsp_stall;
   logic [gqt_pkg::THR_W-1:0] rsp_threshold;
   logic csr_valid;
   logic csr_ready;
   logic [0:0] csr_index;
   logic [gqt_pkg::M_W-1:0] csr_wdata;
   int error_count;
   int pending_count;
   int hold_count;

   gapped_qgram_threshold_dp DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_shape_mask(req_shape_mask),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_threshold(rsp_threshold),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   gqt_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_shape_mask(req_shape_mask),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_threshold(rsp_threshold),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .error_count(error_count), .pending_count(pending_count)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // mostly short idles, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // random shape with span up to the given width
   function automatic logic [gqt_pkg::SHAPE_W-1:0] random_shape(input int max_span);
      int span;
      logic [gqt_pkg::SHAPE_W-1:0] s;
      span = $urandom_range(1, max_span);
      s = gqt_pkg::SHAPE_W'($urandom) & gqt_pkg::SHAPE_W'((32'd1 << span) - 1);
      s[span-1] = 1'b1;
      if ($urandom_range(0, 4) != 0) s[0] = 1'b1;
      return s;
   endfunction

   task automatic csr_write(input gqt_pkg::csr_index_type idx,
                            input logic [gqt_pkg::M_W-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_shape(input logic [gqt_pkg::SHAPE_W-1:0] shape);
      int gap;
      req_shape_mask = shape;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      gap = idle_len();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // stop sending and let every expected word come back
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic set_config(input logic [gqt_pkg::M_W-1:0] m,
                             input logic [gqt_pkg::K_CFG_W-1:0] k);
      csr_write(gqt_pkg::CSR_WINDOW_LENGTH, m);
      csr_write(gqt_pkg::CSR_MAX_MISMATCHES, gqt_pkg::M_W'(k));
   endtask

   // receiver: random stalls, or one long hold-off on request
   initial begin
      int holds_done;
      holds_done = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_count != holds_done) begin
            holds_done++;
            rsp_stall = 1'b1;
            repeat (300) @(negedge clock);
            rsp_stall = 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_stall = 1'b1;
            repeat (idle_len()) @(negedge clock);
         end else begin
            rsp_stall = 1'b0;
            repeat ($urandom_range(0, 20)) @(negedge clock);
         end
      end
   end

   // run time limit
   initial begin
      #60_000_000;
      $display("Verification failed");
      $finish;
   end

   logic [gqt_pkg::SHAPE_W-1:0] directed_shapes[] = '{16'h0001, 16'h0000, 16'h0003, 16'h0005,
      16'h000B, 16'h0013, 16'h00FF, 16'h0081, 16'h8001, 16'hFFFF, 16'h0002, 16'h5555};

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_shape_mask = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      hold_count = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed shapes at the reset config
      foreach (directed_shapes[i]) send_shape(directed_shapes[i]);
      drain();

      // window of zero acts as one, no mismatches
      set_config(7'd0, 2'd0);
      send_shape(16'h0001);
      send_shape(16'h0007);
      send_shape(16'hFFFF);
      drain();

      // oversized window clamps to 64, shapes with span up to 5 only
      set_config(7'd127, 2'd3);
      repeat (12) send_shape(random_shape(5));
      send_shape(16'h0001);
      drain();

      // single position window
      set_config(7'd1, 2'd1);
      repeat (5) send_shape(random_shape(16));
      drain();

      // short window, wide shapes
      set_config(7'd20, 2'd2);
      repeat (30) send_shape(random_shape(16));
      drain();

      // longest legal window without mismatches
      set_config(7'd64, 2'd0);
      repeat (12) send_shape(random_shape(16));
      send_shape(16'h0001);
      drain();

      // receiver holds off while cheap shapes keep coming
      set_config(7'd12, 2'd3);
      @(negedge clock);
      hold_count++;
      repeat (20) send_shape(($urandom_range(0, 1) == 0) ? 16'h0001 : random_shape(4));
      drain();

      // medium window, one mismatch
      set_config(7'd30, 2'd1);
      repeat (25) send_shape(random_shape(16));
      drain();

      if (error_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* gapped_qgram_threshold_dp.f */
+incdir+sv
sv/gqt_pkg.sv
sv/gqt_front.sv
sv/gqt_queue.sv
sv/gqt_back.sv
sv/gapped_qgram_threshold_dp.sv
dv/gqt_checker.sv
dv/tb_gapped_qgram_threshold_dp.sv
